FILE: rtl/trs_pkg.sv
package trs_pkg;

  // Default sizes for the top-level parameters
  localparam int MAX_PERIOD_DEF    = 64;
  localparam int POSITION_BITS_DEF = 32;

  // Fixed field widths
  localparam int CHAR_W      = 8;
  localparam int PERIOD_W    = 7;
  localparam int MIN_LEN_W   = 16;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 2;
  localparam int BASE_W      = 3;

  // Depth of the queue between classifier and reporter
  localparam int QUEUE_DEPTH = 2;

  // Register reset values
  localparam logic [MIN_LEN_W-1:0] MIN_LEN_RESET    = 16'd13;
  localparam logic [PERIOD_W-1:0]  MAX_PERIOD_RESET = 7'd64;

  // Register indexes on the configuration port
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_MIN_REGION_LENGTH = 2'd0,
    REG_MAX_PERIOD        = 2'd1
  } cfg_reg_t;

  // Base codes
  typedef logic [BASE_W-1:0] base_t;
  localparam base_t BASE_A = 3'd0;
  localparam base_t BASE_C = 3'd1;
  localparam base_t BASE_G = 3'd2;
  localparam base_t BASE_T = 3'd3;
  localparam base_t BASE_N = 3'd4;

  // Live configuration seen by both halves
  typedef struct packed {
    logic [MIN_LEN_W-1:0] min_region_length;
    logic [PERIOD_W-1:0]  max_period;
  } cfg_t;

  // ASCII to base code; anything that is not a nucleotide letter is N
  function automatic base_t map_base(input logic [CHAR_W-1:0] c);
    base_t b;
    unique case (c) inside
      8'h41, 8'h61:               b = BASE_A;
      8'h43, 8'h63:               b = BASE_C;
      8'h47, 8'h67:               b = BASE_G;
      8'h54, 8'h74, 8'h55, 8'h75: b = BASE_T;
      default:                    b = BASE_N;
    endcase
    return b;
  endfunction

endpackage

FILE: rtl/tandem_repeat_scan.sv
// Channel  | Handshake            | Payload
// ---------+----------------------+----------------------------------------------------
// seq      | seq_valid/seq_stall  | char_code, end_of_sequence
// region   | region_valid/stall   | region_start, region_end, period, last_of_run
// cfg      | cfg_write_en         | cfg_index, cfg_data
//
// One character per cycle when no streak report is due. A transaction that ends
// R reported streaks holds the reporter until all R are out, one region per cycle
// unless stalled, in ascending period order; a two-entry queue lets characters keep
// coming meanwhile. Reports pass the queue, pending and output registers.
// rst is synchronous: clears streaks, position, queue and config to defaults.
// A stalled region output holds; new characters stall only when the queue fills.
module tandem_repeat_scan #(
  parameter int MAX_PERIOD    = trs_pkg::MAX_PERIOD_DEF,
  parameter int POSITION_BITS = trs_pkg::POSITION_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write_en,
  input  logic [trs_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [trs_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             seq_valid,
  output logic                             seq_stall,
  input  logic [trs_pkg::CHAR_W-1:0]       char_code,
  input  logic                             end_of_sequence,
  output logic                             region_valid,
  input  logic                             region_stall,
  output logic [POSITION_BITS-1:0]         region_start,
  output logic [POSITION_BITS-1:0]         region_end,
  output logic [trs_pkg::PERIOD_W-1:0]     period,
  output logic                             last_of_run
);

  localparam int ITEM_W = 3 * MAX_PERIOD + POSITION_BITS + 1;

  trs_pkg::cfg_t     cfg;
  logic              item_valid;
  logic [ITEM_W-1:0] item_data;
  logic              item_full;
  logic              q_valid;
  logic [ITEM_W-1:0] q_data;
  logic              q_pop;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_region_length <= trs_pkg::MIN_LEN_RESET;
      cfg.max_period        <= trs_pkg::MAX_PERIOD_RESET;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        trs_pkg::REG_MIN_REGION_LENGTH:
          cfg.min_region_length <= cfg_data[trs_pkg::MIN_LEN_W-1:0];
        trs_pkg::REG_MAX_PERIOD:
          cfg.max_period <= cfg_data[trs_pkg::PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  trs_front #(
    .MAX_PERIOD    (MAX_PERIOD),
    .POSITION_BITS (POSITION_BITS),
    .ITEM_W        (ITEM_W)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .seq_valid       (seq_valid),
    .seq_stall       (seq_stall),
    .char_code       (char_code),
    .end_of_sequence (end_of_sequence),
    .item_valid      (item_valid),
    .item_data       (item_data),
    .item_full       (item_full)
  );

  trs_queue #(
    .WIDTH (ITEM_W),
    .DEPTH (trs_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (item_valid),
    .push_data (item_data),
    .full      (item_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (q_data)
  );

  trs_back #(
    .MAX_PERIOD    (MAX_PERIOD),
    .POSITION_BITS (POSITION_BITS),
    .ITEM_W        (ITEM_W)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .item_valid   (q_valid),
    .item_data    (q_data),
    .item_pop     (q_pop),
    .region_valid (region_valid),
    .region_stall (region_stall),
    .region_start (region_start),
    .region_end   (region_end),
    .period       (period),
    .last_of_run  (last_of_run)
  );

endmodule

FILE: rtl/trs_front.sv
module trs_front #(
  parameter int MAX_PERIOD    = trs_pkg::MAX_PERIOD_DEF,
  parameter int POSITION_BITS = trs_pkg::POSITION_BITS_DEF,
  parameter int ITEM_W        = 3 * MAX_PERIOD + POSITION_BITS + 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  trs_pkg::cfg_t               cfg,
  input  logic                        seq_valid,
  output logic                        seq_stall,
  input  logic [trs_pkg::CHAR_W-1:0]  char_code,
  input  logic                        end_of_sequence,
  output logic                        item_valid,
  output logic [ITEM_W-1:0]           item_data,
  input  logic                        item_full
);

  trs_pkg::base_t                   base;
  trs_pkg::base_t                   history [MAX_PERIOD];
  logic [POSITION_BITS-1:0]         position;
  logic [POSITION_BITS-1:0]         position_next;
  logic [trs_pkg::PERIOD_W-1:0]     limit;
  logic [MAX_PERIOD-1:0]            match_vec;
  logic [MAX_PERIOD-1:0]            cmp_vec;
  logic [MAX_PERIOD-1:0]            act_vec;
  logic                             accept;

  assign base       = trs_pkg::map_base(char_code);
  assign accept     = seq_valid && !item_full;
  assign seq_stall  = item_full;
  assign item_valid = seq_valid;

  // Clamp the period limit to what the history holds
  assign limit = (cfg.max_period > trs_pkg::PERIOD_W'(MAX_PERIOD)) ?
                 trs_pkg::PERIOD_W'(MAX_PERIOD) : cfg.max_period;

  // Per-period classification: in range, comparable, matching
  always_comb begin
    for (int j = 0; j < MAX_PERIOD; j++) begin
      act_vec[j]   = trs_pkg::PERIOD_W'(j + 1) <= limit;
      cmp_vec[j]   = act_vec[j] && (position >= POSITION_BITS'(j + 1));
      match_vec[j] = (base != trs_pkg::BASE_N) && (history[j] == base);
    end
  end

  assign item_data = {match_vec, cmp_vec, act_vec, position, end_of_sequence};

  // Base history shift line, newest at tap 0
  always_ff @(posedge clk) begin
    if (accept) begin
      history[0] <= base;
      for (int j = 1; j < MAX_PERIOD; j++) begin
        history[j] <= history[j-1];
      end
    end
  end

  // Position counter, restarts after end of sequence
  assign position_next = end_of_sequence ? '0 : position + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
    end else if (accept) begin
      position <= position_next;
    end
  end

endmodule

FILE: rtl/trs_queue.sv
module trs_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = trs_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             pop_valid,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full      = count == CNT_W'(DEPTH);
  assign pop_valid = count != '0;
  assign pop_data  = entries[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: rtl/trs_back.sv
module trs_back #(
  parameter int MAX_PERIOD    = trs_pkg::MAX_PERIOD_DEF,
  parameter int POSITION_BITS = trs_pkg::POSITION_BITS_DEF,
  parameter int ITEM_W        = 3 * MAX_PERIOD + POSITION_BITS + 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  trs_pkg::cfg_t                 cfg,
  input  logic                          item_valid,
  input  logic [ITEM_W-1:0]             item_data,
  output logic                          item_pop,
  output logic                          region_valid,
  input  logic                          region_stall,
  output logic [POSITION_BITS-1:0]      region_start,
  output logic [POSITION_BITS-1:0]      region_end,
  output logic [trs_pkg::PERIOD_W-1:0]  period,
  output logic                          last_of_run
);

  localparam int SUM_W = (POSITION_BITS >= trs_pkg::MIN_LEN_W) ?
                         POSITION_BITS + 1 : trs_pkg::MIN_LEN_W + 1;

  // Unpacked transaction fields
  logic [MAX_PERIOD-1:0]    match_vec;
  logic [MAX_PERIOD-1:0]    cmp_vec;
  logic [MAX_PERIOD-1:0]    act_vec;
  logic [POSITION_BITS-1:0] item_pos;
  logic                     item_eos;

  // Streak counters, pending reports of the current transaction
  logic [POSITION_BITS-1:0] streak      [MAX_PERIOD];
  logic [POSITION_BITS-1:0] streak_next [MAX_PERIOD];
  logic [MAX_PERIOD-1:0]    pending;
  logic [MAX_PERIOD-1:0]    pending_next;
  logic [MAX_PERIOD-1:0]    end_late;
  logic [MAX_PERIOD-1:0]    end_late_next;
  logic [POSITION_BITS-1:0] cur_pos;

  // Report selection
  logic                         take;
  logic                         emit;
  logic [MAX_PERIOD-1:0]        sel;
  logic [POSITION_BITS-1:0]     sel_streak;
  logic [trs_pkg::PERIOD_W-1:0] sel_period;
  logic                         sel_late;
  logic [POSITION_BITS-1:0]     rep_end;

  function automatic logic qualifies(input logic [POSITION_BITS-1:0] s,
                                     input logic [POSITION_BITS-1:0] k,
                                     input logic [trs_pkg::MIN_LEN_W-1:0] min_len);
    return (s >= k) && ((SUM_W'(s) + SUM_W'(k)) >= SUM_W'(min_len));
  endfunction

  assign {match_vec, cmp_vec, act_vec, item_pos, item_eos} = item_data;

  // Next transaction enters once every report of the last one is out
  assign take     = item_valid && (pending == '0);
  assign item_pop = take;

  // Streak update for all periods at once
  always_comb begin
    logic [POSITION_BITS-1:0] s;
    logic [POSITION_BITS-1:0] s_mid;
    logic [POSITION_BITS-1:0] kk;
    logic                     rep_mis;
    logic                     rep_eos;
    for (int j = 0; j < MAX_PERIOD; j++) begin
      s       = streak[j];
      kk      = POSITION_BITS'(j + 1);
      s_mid   = s;
      rep_mis = 1'b0;
      rep_eos = 1'b0;
      if (act_vec[j]) begin
        if (cmp_vec[j]) begin
          if (match_vec[j]) begin
            s_mid = (s == '1) ? s : s + 1'b1;
          end else begin
            rep_mis = qualifies(s, kk, cfg.min_region_length);
            s_mid   = '0;
          end
        end
        rep_eos = item_eos && qualifies(s_mid, kk, cfg.min_region_length);
        // A reported streak holds its length until sent, then clears
        if (rep_mis) begin
          streak_next[j] = s;
        end else if (rep_eos || !item_eos) begin
          streak_next[j] = s_mid;
        end else begin
          streak_next[j] = '0;
        end
      end else begin
        streak_next[j] = '0;
      end
      pending_next[j]  = rep_mis || rep_eos;
      end_late_next[j] = rep_eos;
    end
  end

  // Lowest pending period goes out first
  assign sel  = pending & (~pending + 1'b1);
  assign emit = (pending != '0) && (!region_valid || !region_stall);

  always_comb begin
    sel_streak = '0;
    sel_period = '0;
    sel_late   = 1'b0;
    for (int j = 0; j < MAX_PERIOD; j++) begin
      sel_streak = sel_streak | (streak[j] & {POSITION_BITS{sel[j]}});
      sel_period = sel_period | (trs_pkg::PERIOD_W'(j + 1) & {trs_pkg::PERIOD_W{sel[j]}});
      sel_late   = sel_late | (end_late[j] & sel[j]);
    end
  end

  assign rep_end = sel_late ? cur_pos + 1'b1 : cur_pos;

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      pending      <= '0;
      region_valid <= 1'b0;
      for (int j = 0; j < MAX_PERIOD; j++) begin
        streak[j] <= '0;
      end
    end else begin
      if (take) begin
        pending <= pending_next;
        for (int j = 0; j < MAX_PERIOD; j++) begin
          streak[j] <= streak_next[j];
        end
      end else if (emit) begin
        pending <= pending & ~sel;
        for (int j = 0; j < MAX_PERIOD; j++) begin
          if (sel[j]) begin
            streak[j] <= '0;
          end
        end
      end
      if (emit) begin
        region_valid <= 1'b1;
      end else if (!region_stall) begin
        region_valid <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (take) begin
      end_late <= end_late_next;
      cur_pos  <= item_pos;
    end
    if (emit) begin
      region_end   <= rep_end;
      region_start <= rep_end - sel_streak - POSITION_BITS'(sel_period);
      period       <= sel_period;
      last_of_run  <= (pending & ~sel) == '0;
    end
  end

endmodule

FILE: rtl/trs_checker.sv
module trs_checker #(
  parameter int POSITION_BITS = trs_pkg::POSITION_BITS_DEF
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         region_valid,
  input logic                         region_stall,
  input logic [POSITION_BITS-1:0]     region_start,
  input logic [POSITION_BITS-1:0]     region_end,
  input logic [trs_pkg::PERIOD_W-1:0] period,
  input logic                         last_of_run
);

  // Nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !region_valid)
    else $error("region output valid after reset");

  // Stalled region holds its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    region_valid && region_stall |=> region_valid &&
      $stable({region_start, region_end, period, last_of_run}))
    else $error("stalled region changed");

  // Period zero is never scanned
  a_period: assert property (@(posedge clk) disable iff (rst)
    region_valid |-> period != '0)
    else $error("region with period zero");

  // Within one transaction, regions follow back to back in rising period order
  a_order: assert property (@(posedge clk) disable iff (rst)
    region_valid && !region_stall && !last_of_run |=>
      region_valid && (period > $past(period)))
    else $error("regions of one transaction out of order or gapped");

endmodule

bind tandem_repeat_scan trs_checker #(
  .POSITION_BITS (POSITION_BITS)
) u_trs_checker (
  .clk          (clk),
  .rst          (rst),
  .region_valid (region_valid),
  .region_stall (region_stall),
  .region_start (region_start),
  .region_end   (region_end),
  .period       (period),
  .last_of_run  (last_of_run)
);
